// ===== rtl/tphi_pkg.sv =====
// ----------------------------------------------------------------------------
// tphi_pkg
// Shared types and constants of the timed pose history interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tphi_pkg;

  localparam int unsigned TimeW          = 48;
  localparam int unsigned PosW           = 32;
  localparam int unsigned HeadW          = 16;
  localparam int unsigned PoseW          = 2 * PosW + HeadW;
  localparam int unsigned DefHistDepth   = 64;
  localparam int unsigned DefAlphaBits   = 16;
  localparam logic [TimeW-1:0] RetentionReset = 48'd1000000000;

  localparam logic ReqAdd   = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [TimeW-1:0]        sample_time;
    logic signed [PosW-1:0]  pos_x_in;
    logic signed [PosW-1:0]  pos_y_in;
    logic [HeadW-1:0]        heading_in;
  } req_t;

  typedef struct packed {
    logic                    pose_found;
    logic signed [PosW-1:0]  pos_x_out;
    logic signed [PosW-1:0]  pos_y_out;
    logic [HeadW-1:0]        heading_out;
    logic                    history_nonempty;
    logic [TimeW-1:0]        newest_time;
  } rsp_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic [HeadW-1:0]       h;
  } pose_t;

endpackage

`default_nettype wire

// ===== rtl/tphi_ram.sv =====
// ----------------------------------------------------------------------------
// tphi_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tphi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/tphi_div.sv =====
// ----------------------------------------------------------------------------
// tphi_div
// Restoring fraction divider: floor(num * 2^FracBits / den) for num < den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tphi_div #(
  parameter int unsigned FracBits = tphi_pkg::DefAlphaBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tphi_pkg::TimeW-1:0]   num_i,
  input  wire logic [tphi_pkg::TimeW-1:0]   den_i,
  output logic                              done_o,
  output logic [FracBits-1:0]               quot_o
);

  localparam int unsigned CntW = $clog2(FracBits + 1);

  logic [tphi_pkg::TimeW:0]   rem_q, rem_d, shifted;
  logic [tphi_pkg::TimeW-1:0] den_q, den_d;
  logic [FracBits-1:0]        quot_q, quot_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;

  always_comb begin
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q[tphi_pkg::TimeW-1:0], 1'b0};
    done_o  = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d  = shifted - {1'b0, den_q};
        quot_d = {quot_q[FracBits-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[FracBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(FracBits - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quot_o = quot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

endmodule

`default_nettype wire

// ===== rtl/tphi_blend.sv =====
// ----------------------------------------------------------------------------
// tphi_blend
// Linear blend of two poses by a fractional weight, with the heading taking
// the shortest wrapped path. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tphi_blend #(
  parameter int unsigned FracBits = tphi_pkg::DefAlphaBits
) (
  input  wire logic                  clk_i,
  input  wire logic [FracBits-1:0]   alpha_i,
  input  wire tphi_pkg::pose_t       p0_i,
  input  wire tphi_pkg::pose_t       p1_i,
  output tphi_pkg::pose_t            pose_o
);

  localparam int unsigned DW = tphi_pkg::PosW + 1;
  localparam int unsigned PW = DW + FracBits + 1;

  logic signed [DW-1:0]  dx, dy, dh;
  logic signed [PW-1:0]  mx_q, my_q, mh_q;
  tphi_pkg::pose_t       p0_q;
  logic [tphi_pkg::HeadW-1:0] hdiff;
  logic signed [PW-1:0]  sx, sy, sh;

  always_comb begin
    hdiff = p1_i.h - p0_i.h;
    dx = DW'(p1_i.x) - DW'(p0_i.x);
    dy = DW'(p1_i.y) - DW'(p0_i.y);
    if (hdiff > 16'd32768) begin
      dh = DW'($signed({1'b0, hdiff})) - DW'(32'sd65536);
    end else begin
      dh = DW'($signed({1'b0, hdiff}));
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= p0_i;
    mx_q <= $signed({1'b0, alpha_i}) * dx;
    my_q <= $signed({1'b0, alpha_i}) * dy;
    mh_q <= $signed({1'b0, alpha_i}) * dh;
  end

  always_comb begin
    sx = mx_q >>> FracBits;
    sy = my_q >>> FracBits;
    sh = mh_q >>> FracBits;
  end

  always_ff @(posedge clk_i) begin
    pose_o.x <= p0_q.x + sx[tphi_pkg::PosW-1:0];
    pose_o.y <= p0_q.y + sy[tphi_pkg::PosW-1:0];
    pose_o.h <= p0_q.h + sh[tphi_pkg::HeadW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/timed_pose_history_interpolator.sv =====
// ----------------------------------------------------------------------------
// timed_pose_history_interpolator
// Ring of timestamped poses in two RAMs with time-ordered append, retention
// trim and binary-search query with linear interpolation.
// ----------------------------------------------------------------------------
// Steps: an add at the newest time overwrites that entry; other adds append and then
// trim old entries one at a time. A query outside the span is answered from idle;
// others run a binary search, plus a divide and a blend when interpolating.
// Throughput: one request at a time; the next is taken once the response has left.
// Reset: history empty, window 1000000000 ns; RAM contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_pose_history_interpolator #(
  parameter int unsigned HistoryDepth  = tphi_pkg::DefHistDepth,
  parameter int unsigned AlphaFracBits = tphi_pkg::DefAlphaBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire tphi_pkg::req_t              in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output tphi_pkg::rsp_t                   out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tphi_pkg::TimeW-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(HistoryDepth);
  localparam int unsigned CW = $clog2(HistoryDepth + 1);
  localparam int unsigned TW = tphi_pkg::TimeW;

  typedef enum logic [12:0] {
    StIdle   = 13'b0000000000001,
    StAddRd  = 13'b0000000000010,
    StTrimRd = 13'b0000000000100,
    StTrimCk = 13'b0000000001000,
    StQRd    = 13'b0000000010000,
    StQCk    = 13'b0000000100000,
    StQHit   = 13'b0000001000000,
    StQHitW  = 13'b0000010000000,
    StQLo    = 13'b0000100000000,
    StDiv    = 13'b0001000000000,
    StBlend  = 13'b0010000000000,
    StOut    = 13'b0100000000000,
    StQPose  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [TW-1:0]  window_q;
  logic [AW-1:0]  oldest_q, oldest_d;
  logic [CW-1:0]  count_q, count_d;
  logic [TW-1:0]  newest_q, newest_d;
  logic [TW-1:0]  oldest_t_q, oldest_t_d;
  tphi_pkg::req_t req_q;
  logic [CW-1:0]  lo_q, lo_d, hi_q, hi_d, mid;
  logic [TW-1:0]  t0_q, t0_d, t1_q, t1_d;
  tphi_pkg::pose_t p1_q, p1_d;
  logic [1:0]     bcnt_q, bcnt_d;
  tphi_pkg::rsp_t rsp_q, rsp_d;
  logic           ovalid_q, ovalid_d;

  logic           t_we, p_we;
  logic [AW-1:0]  addr;
  logic [TW-1:0]  t_rd;
  tphi_pkg::pose_t p_rd, p_wr;
  logic           div_start, div_done;
  logic [AlphaFracBits-1:0] alpha_q, alpha_d, quot;
  tphi_pkg::pose_t blend_pose;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = {1'b0, CW'(base)} + {1'b0, idx};
    if (s >= (CW+1)'(HistoryDepth)) begin
      s = s - (CW+1)'(HistoryDepth);
    end
    return s[AW-1:0];
  endfunction

  tphi_ram #(.Width(TW), .Depth(HistoryDepth)) u_time_ram (
    .clk_i, .we_i(t_we), .addr_i(addr), .wdata_i(req_q.sample_time), .rdata_o(t_rd)
  );

  tphi_ram #(.Width(tphi_pkg::PoseW), .Depth(HistoryDepth)) u_pose_ram (
    .clk_i, .we_i(p_we), .addr_i(addr), .wdata_i(p_wr), .rdata_o(p_rd)
  );

  tphi_div #(.FracBits(AlphaFracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(req_q.sample_time - t0_q),
    .den_i(t1_q - t0_q), .done_o(div_done), .quot_o(quot)
  );

  tphi_blend #(.FracBits(AlphaFracBits)) u_blend (
    .clk_i, .alpha_i(alpha_q), .p0_i(p_rd), .p1_i(p1_q), .pose_o(blend_pose)
  );

  assign p_wr = '{x: req_q.pos_x_in, y: req_q.pos_y_in, h: req_q.heading_in};
  assign in_ready_o  = (state_q == StIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = rsp_q;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    state_d    = state_q;
    oldest_d   = oldest_q;
    count_d    = count_q;
    newest_d   = newest_q;
    oldest_t_d = oldest_t_q;
    lo_d = lo_q; hi_d = hi_q;
    t0_d = t0_q; t1_d = t1_q;
    p1_d = p1_q;
    bcnt_d = bcnt_q;
    alpha_d = alpha_q;
    rsp_d = rsp_q;
    ovalid_d = ovalid_q;
    t_we = 1'b0; p_we = 1'b0;
    addr = oldest_q;
    div_start = 1'b0;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.req_type == tphi_pkg::ReqAdd) begin
            state_d = StAddRd;
          end else if (count_q != '0 && in_data_i.sample_time >= oldest_t_q &&
                       in_data_i.sample_time <= newest_q) begin
            lo_d = '0;
            hi_d = count_q;
            state_d = StQRd;
          end else begin
            rsp_d = '{pose_found: 1'b0, pos_x_out: '0, pos_y_out: '0,
                      heading_out: '0, history_nonempty: count_q != '0,
                      newest_time: count_q != '0 ? newest_q : '0};
            ovalid_d = 1'b1;
          end
        end
      end
      StAddRd: begin
        // Decide clear, overwrite or append with the cached newest time.
        if (count_q != '0 && req_q.sample_time == newest_q) begin
          addr = slot_of(oldest_q, count_q - 1'b1);
          p_we = 1'b1;
          state_d = StOut;
        end else begin
          logic [AW-1:0] ob;
          logic [CW-1:0] cb;
          ob = oldest_q;
          cb = count_q;
          if (count_q != '0 && req_q.sample_time < newest_q) begin
            cb = '0;
          end
          if (cb == CW'(HistoryDepth)) begin
            ob = slot_of(ob, CW'(1));
            cb = cb - 1'b1;
          end
          addr = slot_of(ob, cb);
          t_we = 1'b1;
          p_we = 1'b1;
          oldest_d = ob;
          count_d = cb + 1'b1;
          newest_d = req_q.sample_time;
          if (cb == '0) begin
            oldest_t_d = req_q.sample_time;
          end
          state_d = StTrimRd;
        end
      end
      StTrimRd: begin
        addr = oldest_q;
        state_d = StTrimCk;
      end
      StTrimCk: begin
        oldest_t_d = t_rd;
        if (count_q > CW'(1) && newest_q - t_rd > window_q) begin
          oldest_d = slot_of(oldest_q, CW'(1));
          count_d = count_q - 1'b1;
          state_d = StTrimRd;
        end else begin
          state_d = StOut;
        end
      end
      StQRd: begin
        if (lo_q < hi_q) begin
          addr = slot_of(oldest_q, mid);
          state_d = StQCk;
        end else begin
          addr = slot_of(oldest_q, lo_q);
          state_d = StQHit;
        end
      end
      StQCk: begin
        if (t_rd < req_q.sample_time) begin
          lo_d = mid + 1'b1;
        end else begin
          hi_d = mid;
        end
        state_d = StQRd;
      end
      StQHit: begin
        t1_d = t_rd;
        p1_d = p_rd;
        if (lo_q == '0 || t_rd == req_q.sample_time) begin
          state_d = StQPose;
        end else begin
          addr = slot_of(oldest_q, lo_q - 1'b1);
          state_d = StQLo;
        end
      end
      StQLo: begin
        t0_d = t_rd;
        state_d = StQHitW;
      end
      StQHitW: begin
        div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        addr = slot_of(oldest_q, lo_q - 1'b1);
        if (div_done) begin
          alpha_d = quot;
          bcnt_d = '0;
          state_d = StBlend;
        end
      end
      StBlend: begin
        addr = slot_of(oldest_q, lo_q - 1'b1);
        bcnt_d = bcnt_q + 1'b1;
        if (bcnt_q == 2'd2) begin
          rsp_d = '{pose_found: 1'b1, pos_x_out: blend_pose.x,
                    pos_y_out: blend_pose.y, heading_out: blend_pose.h,
                    history_nonempty: 1'b1, newest_time: newest_q};
          ovalid_d = 1'b1;
          state_d = StIdle;
        end
      end
      StQPose: begin
        rsp_d = '{pose_found: 1'b1, pos_x_out: p1_q.x, pos_y_out: p1_q.y,
                  heading_out: p1_q.h, history_nonempty: 1'b1,
                  newest_time: newest_q};
        ovalid_d = 1'b1;
        state_d = StIdle;
      end
      StOut: begin
        rsp_d = '{pose_found: 1'b0, pos_x_out: '0, pos_y_out: '0,
                  heading_out: '0, history_nonempty: 1'b1, newest_time: newest_q};
        ovalid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      window_q <= tphi_pkg::RetentionReset;
      oldest_q <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      bcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        window_q <= cfg_data_i;
      end
      oldest_q <= oldest_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
      bcnt_q   <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    newest_q   <= newest_d;
    oldest_t_q <= oldest_t_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    t0_q <= t0_d;
    t1_q <= t1_d;
    p1_q <= p1_d;
    alpha_q <= alpha_d;
    rsp_q <= rsp_d;
  end

  // Assertions.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(HistoryDepth))
    else $error("entry count exceeds depth");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o)
    else $error("request accepted while busy");

  a_found_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pose_found) |-> out_data_o.history_nonempty)
    else $error("pose found on empty history");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StQRd) |-> (lo_q <= hi_q && hi_q <= count_q))
    else $error("search bounds broken");

endmodule

`default_nettype wire
